// File: hdl/scar_pkg.sv
// ----------------------------------------------------------------------------
// scar_pkg
// Shared types, constants and helpers for the three-channel serial ADC reader.
// ----------------------------------------------------------------------------
package scar_pkg;

  // Number of data lines that share the serial clock.
  localparam int CHANNELS    = 3;
  // Bits shifted out of each converter per conversion.
  localparam int SAMPLE_BITS = 24;

  // Fixed field widths of the streams.
  localparam int LINE_W = 3;
  localparam int RAW_W  = 24;
  localparam int MS_W   = 16;
  localparam int CNT_W  = 5;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 104;

  localparam logic [LINE_W-1:0] ALL_CH = LINE_W'((1 << CHANNELS) - 1);

  localparam logic [MS_W-1:0]  TIMEOUT_RESET = 16'd100;
  localparam logic [MS_W-1:0]  WAIT_MAX      = 16'hFFFF;
  localparam logic [CNT_W-1:0] LAST_PULSE    = CNT_W'(SAMPLE_BITS + 1);
  localparam logic [CNT_W-1:0] SHIFT_PULSES  = CNT_W'(SAMPLE_BITS);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TIMEOUT   = 2'd1,
    ST_STUCK_LOW = 2'd2
  } status_t;

  // Sign-extend the low SAMPLE_BITS bits of a sample to the full raw width.
  function automatic logic [RAW_W-1:0] extend_sample(input logic [RAW_W-1:0] v);
    logic [RAW_W-1:0] r;
    for (int i = 0; i < RAW_W; i++) begin
      r[i] = (i < SAMPLE_BITS) ? v[i] : v[SAMPLE_BITS-1];
    end
    return r;
  endfunction

endpackage : scar_pkg

// File: hdl/shared_clock_three_adc_reader_core.sv
// ----------------------------------------------------------------------------
// shared_clock_three_adc_reader_core
// Group readout of three serial sigma-delta converters on one shared clock.
// ----------------------------------------------------------------------------
// Every input request stands for one half period of the shared serial clock
// and carries the sampled data-line levels, a millisecond tick and a start
// flag; every input request produces exactly one output request, which tells
// the level to drive on the clock line for that half period. A start (tuser
// high while idle) records which lines are already low, then waits until all
// lines are low, counting millisecond ticks; reaching ready_timeout_ms first
// ends the read with a timeout and a stuck-high mask. Once ready, the block
// clocks SAMPLE_BITS bits (MSB first, sampled while the clock is high), gives
// one extra pulse, checks that all lines went high again (else stuck-low) and,
// on success, records on one more half period which lines are already low
// again. The output request that ends a group read carries tlast high and the
// full result; all other output requests carry only the clock level. The block
// takes one request per clock cycle while the output side does not stall:
// the state update and the result are one level of logic between the state
// registers and the output register, and a new request is accepted whenever
// the output register is empty or is being drained in the same cycle; the
// output request is registered.
module shared_clock_three_adc_reader_core (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration: ready timeout in milliseconds.
  input  logic                               cfg_we,
  input  logic [scar_pkg::MS_W-1:0]          cfg_wdata,
  // Input stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [2:0] dout_levels, [3] ms_tick, [7:4] zero
  input  logic [scar_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [0] command
  input  logic                               s_axis_tuser,
  // Output stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] sck_level, [24:1] raw_ch0, [48:25] raw_ch1, [72:49] raw_ch2,
  // [88:73] wait time in ms, [91:89] lines low at start,
  // [94:92] stuck-high lines, [97:95] stuck-low lines,
  // [100:98] early_ready_mask, [103:101] valid lines
  output logic [scar_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // done_res
  output logic                               m_axis_tlast,
  // [1:0] status
  output logic [1:0]                         m_axis_tuser
);
  import scar_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT,
    PH_HIGH,
    PH_LOW,
    PH_POST,
    PH_EARLY
  } phase_t;

  // Sequencer state.
  phase_t            phase, phase_next;
  logic [CNT_W-1:0]  pulse_counter, pulse_counter_next;
  logic [RAW_W-1:0]  channel_shift [CHANNELS];
  logic [RAW_W-1:0]  channel_shift_next [CHANNELS];
  logic [MS_W-1:0]   wait_counter, wait_counter_next;
  logic [LINE_W-1:0] first_ready_mask, first_ready_mask_next;
  logic [MS_W-1:0]   ready_timeout_ms;

  // Output register.
  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data, out_data_next;
  logic                  out_last, out_last_next;
  logic [1:0]            out_user, out_user_next;

  // Unpacked input request.
  logic              command;
  logic [LINE_W-1:0] dout_levels;
  logic              ms_tick;
  logic [LINE_W-1:0] low;
  logic              in_accept;

  // Result fields before packing.
  logic              sck_level;
  logic              finish;
  status_t           status;
  logic [LINE_W-1:0] stuck_high, stuck_low, early_ready;
  logic [RAW_W-1:0]  raw [LINE_W];
  logic [MS_W-1:0]   wait_out;
  logic [LINE_W-1:0] ok_lines;

  assign command     = s_axis_tuser;
  assign dout_levels = s_axis_tdata[LINE_W-1:0];
  assign ms_tick     = s_axis_tdata[LINE_W];
  // Lines of absent channels are masked out; a low line means that channel is ready.
  assign low         = ~dout_levels & ALL_CH;

  // The output register frees up in the same cycle it is drained.
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Next state and the result of the current half period.
  always_comb begin
    phase_next            = phase;
    pulse_counter_next    = pulse_counter;
    wait_counter_next     = wait_counter;
    first_ready_mask_next = first_ready_mask;
    for (int c = 0; c < CHANNELS; c++) begin
      channel_shift_next[c] = channel_shift[c];
    end
    sck_level   = 1'b0;
    finish      = 1'b0;
    status      = ST_OK;
    stuck_high  = '0;
    stuck_low   = '0;
    early_ready = '0;

    unique case (phase)
      PH_IDLE: begin
        if (command) begin
          for (int c = 0; c < CHANNELS; c++) begin
            channel_shift_next[c] = '0;
          end
          pulse_counter_next    = '0;
          wait_counter_next     = '0;
          first_ready_mask_next = low;
          phase_next            = (low == ALL_CH) ? PH_HIGH : PH_WAIT;
        end
      end
      PH_WAIT: begin
        priority if (low == ALL_CH) begin
          phase_next = PH_HIGH;
        end else if (wait_counter >= ready_timeout_ms) begin
          finish     = 1'b1;
          status     = ST_TIMEOUT;
          stuck_high = ALL_CH & ~low;
          phase_next = PH_IDLE;
        end else if (ms_tick && wait_counter != WAIT_MAX) begin
          wait_counter_next = wait_counter + MS_W'(1);
        end
      end
      PH_HIGH: begin
        // Data is sampled while the clock is high; the extra pulse shifts nothing.
        sck_level = 1'b1;
        if (pulse_counter < SHIFT_PULSES) begin
          for (int c = 0; c < CHANNELS; c++) begin
            channel_shift_next[c] = {channel_shift[c][RAW_W-2:0], dout_levels[c]};
          end
        end
        phase_next = PH_LOW;
      end
      PH_LOW: begin
        pulse_counter_next = pulse_counter + CNT_W'(1);
        phase_next = (pulse_counter_next >= LAST_PULSE) ? PH_POST : PH_HIGH;
      end
      PH_POST: begin
        if (low != '0) begin
          finish     = 1'b1;
          status     = ST_STUCK_LOW;
          stuck_low  = low;
          phase_next = PH_IDLE;
        end else begin
          phase_next = PH_EARLY;
        end
      end
      PH_EARLY: begin
        finish      = 1'b1;
        status      = ST_OK;
        early_ready = low;
        phase_next  = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    for (int c = 0; c < LINE_W; c++) begin
      if (c < CHANNELS && finish && status != ST_TIMEOUT) begin
        raw[c] = extend_sample(channel_shift[c]);
      end else begin
        raw[c] = '0;
      end
    end
    wait_out = (finish && status != ST_TIMEOUT) ? wait_counter : '0;
    ok_lines = (finish && status == ST_OK) ? ALL_CH : '0;

    out_data_next = {ok_lines, early_ready, stuck_low, stuck_high,
                     finish ? first_ready_mask : {LINE_W{1'b0}},
                     wait_out, raw[2], raw[1], raw[0], sck_level};
    out_last_next = finish;
    out_user_next = finish ? 2'(status) : 2'(ST_OK);
  end

  // State, configuration and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      pulse_counter    <= '0;
      wait_counter     <= '0;
      first_ready_mask <= '0;
      ready_timeout_ms <= TIMEOUT_RESET;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        ready_timeout_ms <= cfg_wdata;
      end
      if (in_accept) begin
        phase            <= phase_next;
        pulse_counter    <= pulse_counter_next;
        wait_counter     <= wait_counter_next;
        first_ready_mask <= first_ready_mask_next;
        out_valid        <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Sample registers and result payload need no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int c = 0; c < CHANNELS; c++) begin
        channel_shift[c] <= channel_shift_next[c];
      end
      out_data <= out_data_next;
      out_last <= out_last_next;
      out_user <= out_user_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_user;

`ifndef ASSERT_OFF
  // The pulse counter never runs past the extra pulse.
  a_pulse_range: assert property (@(posedge clk) disable iff (rst)
    pulse_counter <= LAST_PULSE)
    else $error("pulse counter out of range");

  // A clock-high half period is always followed by a clock-low one.
  a_high_then_low: assert property (@(posedge clk) disable iff (rst)
    (in_accept && phase == PH_HIGH) |=> (phase == PH_LOW))
    else $error("clock high not followed by clock low");

  // Only a finishing request carries a status or result fields.
  a_quiet_unless_done: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |->
      (m_axis_tuser == 2'(ST_OK) && m_axis_tdata[OUT_DATA_W-1:1] == '0))
    else $error("result fields on a non-finishing request");

  // A successful read marks every channel valid, a failed one none.
  a_valid_lines: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |->
      ((m_axis_tuser == 2'(ST_OK)) ==
       (m_axis_tdata[OUT_DATA_W-1:OUT_DATA_W-LINE_W] == ALL_CH)))
    else $error("valid lines disagree with status");

  // The output register is empty after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");
`endif

endmodule : shared_clock_three_adc_reader_core
